FILE: rtl/bpq_pkg.sv
// Package for the bounded priority queue: item kinds, cell commands and entry type.
`default_nettype none
package bpq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned KindW  = 2;

  localparam logic [PrioW-1:0] MaxPrioReset = 8'd15;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH      = 2'd0,
    KIND_PUSH_PRIO = 2'd1,
    KIND_POP       = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic                     valid;
    logic [PrioW-1:0]         prio;
    logic signed [ValueW-1:0] value;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    cell_op_t                 op;
    logic                     plain;  // tail push: stop at first empty cell
    logic [PrioW-1:0]         prio;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

endpackage : bpq_pkg
`default_nettype wire

FILE: rtl/bpq_cell.sv
// One queue slot: holds an entry, shifts toward the tail on insert, toward the head on pop.
`default_nettype none
module bpq_cell
  import bpq_pkg::*;
#(
  parameter bit IS_HEAD = 1'b0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire entry_t    left_ent,    // neighbor closer to the head
  input  wire entry_t    right_ent,   // neighbor closer to the tail
  input  wire logic      passed_in,   // insertion point lies in front of this cell
  output logic           passed_out,
  output entry_t         ent
);

  logic                     valid_r, valid_nxt;
  logic [PrioW-1:0]         prio_r, prio_nxt;
  logic signed [ValueW-1:0] value_r, value_nxt;
  logic                     stop;

  // head takes a new entry only on a strictly lower number; later cells on a lower or equal one
  always_comb begin
    if (IS_HEAD) begin
      stop = !valid_r || (!cmd.plain && (cmd.prio < prio_r));
    end else begin
      stop = !valid_r || (!cmd.plain && (prio_r >= cmd.prio));
    end
  end

  assign passed_out = passed_in | stop;

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    value_nxt = value_r;
    case (cmd.op)
      OP_INSERT: begin
        if (passed_in) begin
          valid_nxt = left_ent.valid;
          prio_nxt  = left_ent.prio;
          value_nxt = left_ent.value;
        end else if (stop) begin
          valid_nxt = 1'b1;
          prio_nxt  = cmd.prio;
          value_nxt = cmd.value;
        end
      end
      OP_POP: begin
        valid_nxt = right_ent.valid;
        prio_nxt  = right_ent.prio;
        value_nxt = right_ent.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r  <= prio_nxt;
    value_r <= value_nxt;
  end

  assign ent = '{valid: valid_r, prio: prio_r, value: value_r};

endmodule : bpq_cell
`default_nettype wire

FILE: rtl/bounded_priority_queue_top.sv
// Top level of the bounded priority queue: cell chain, occupancy, config and result register.
`default_nettype none
// Sorted-list priority queue built as a chain of DEPTH cells, head in cell 0.
// Every cell compares its stored priority with the request and an OR chain
// through the cells marks the insertion point, so a push or pop shifts the
// whole row together. The result goes into an output register; a new beat is
// taken while that register is empty or being drained, so the block sustains
// one item per cycle and stalls only when the output side holds back. The
// longest path is the insertion-point OR chain, which grows linearly with DEPTH.
// max_priority may be written at any time the block is idle (reset value 15).
module bounded_priority_queue_top
  import bpq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config: max_priority
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], priority_req[39:32]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // popped_value[31:0], pop_valid[32],
                                       // was_empty[33], push_dropped[34],
                                       // entry_count[39:35]
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);

  logic [PrioW-1:0] max_prio_r;
  logic [OccW-1:0]  occ_r, occ_nxt;
  logic             out_valid_r;
  logic [39:0]      out_data_r;

  logic             in_beat;
  kind_t            kind;
  logic [PrioW-1:0] req_prio;
  logic [PrioW-1:0] clamped;
  logic             full, empty;
  cell_cmd_t        cmd;

  logic             pop_valid, was_empty, push_dropped;
  logic signed [ValueW-1:0] popped;
  logic [CountW-1:0] count_out;

  entry_t           ents   [DEPTH];
  logic [DEPTH:0]   passed;
  logic [DEPTH-1:0] valid_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_prio_r <= MaxPrioReset;
    end else if (cfg_valid) begin
      max_prio_r <= cfg_data;
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign kind      = kind_t'(in_tuser);
  assign req_prio  = in_tdata[39:32];
  assign clamped   = (req_prio > max_prio_r) ? max_prio_r : req_prio;
  assign full      = (occ_r == OccW'(DEPTH));
  assign empty     = (occ_r == '0);

  always_comb begin
    cmd.op       = OP_HOLD;
    cmd.plain    = 1'b1;
    cmd.prio     = max_prio_r;
    cmd.value    = in_tdata[ValueW-1:0];
    pop_valid    = 1'b0;
    was_empty    = 1'b0;
    push_dropped = 1'b0;
    popped       = '0;
    occ_nxt      = occ_r;
    case (kind)
      KIND_PUSH, KIND_PUSH_PRIO: begin
        if (full) begin
          push_dropped = 1'b1;
        end else begin
          cmd.op  = in_beat ? OP_INSERT : OP_HOLD;
          occ_nxt = occ_r + OccW'(1);
          if (kind == KIND_PUSH_PRIO) begin
            cmd.plain = 1'b0;
            cmd.prio  = clamped;
          end
        end
      end
      KIND_POP: begin
        if (empty) begin
          was_empty = 1'b1;
        end else begin
          cmd.op    = in_beat ? OP_POP : OP_HOLD;
          pop_valid = 1'b1;
          popped    = ents[0].value;
          occ_nxt   = occ_r - OccW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign passed[0] = 1'b0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_t left_ent, right_ent;
      if (i == 0) begin : g_left_head
        assign left_ent = '0;
      end else begin : g_left
        assign left_ent = ents[i-1];
      end
      if (i == DEPTH - 1) begin : g_right_tail
        assign right_ent = '0;
      end else begin : g_right
        assign right_ent = ents[i+1];
      end

      bpq_cell #(
        .IS_HEAD (i == 0)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .left_ent   (left_ent),
        .right_ent  (right_ent),
        .passed_in  (passed[i]),
        .passed_out (passed[i+1]),
        .ent        (ents[i])
      );

      assign valid_vec[i] = ents[i].valid;
    end

    // entry_count wraps at 32
    if (OccW >= CountW) begin : g_cnt_trunc
      assign count_out = occ_nxt[CountW-1:0];
    end else begin : g_cnt_ext
      assign count_out = {{(CountW - OccW){1'b0}}, occ_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        occ_r <= occ_nxt;
      end
      if (in_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_data_r <= {count_out, push_dropped, was_empty, pop_valid, popped};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // occupied cells always match the count
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("cell valid bits disagree with occupancy");

  // a full queue has its tail cell occupied
  a_full_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> valid_vec[DEPTH-1])
    else $error("queue full but tail cell empty");

  a_pop_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[32] && out_data_r[33]))
    else $error("pop reported both a value and an empty queue");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && kind == KIND_POP && !empty) |=> (occ_r == $past(occ_r) - OccW'(1)))
    else $error("pop did not remove one entry");

endmodule : bounded_priority_queue_top
`default_nettype wire
